// ===== design/conv3_pkg.sv =====
// Package: constants, types and tap arithmetic for the 3x3 stream convolver.
`timescale 1ns / 1ps
`default_nettype none
package conv3_pkg;

    localparam int MAX_WIDTH    = 1024;
    localparam int PIXEL_BITS   = 16;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int WIDTH_W      = COL_W + 1;
    localparam int ROW_W        = 16;
    localparam int ACC_W        = PIXEL_BITS + 3;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = QPTR_W + 1;

    localparam int RESET_WIDTH  = 1024;
    localparam int RESET_HEIGHT = 1024;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    typedef logic signed [PIXEL_BITS-1:0] t_pix;
    typedef logic signed [ACC_W-1:0]      t_acc;
    typedef logic [COL_W-1:0]             t_col;
    typedef logic [WIDTH_W-1:0]           t_width;
    typedef logic [ROW_W-1:0]             t_row;

    typedef struct packed {
        t_acc result;
        t_row row;
        t_col col;
        logic frame_end;
        logic last;
    } t_res;

    function automatic t_acc sx(input t_pix p);
        return t_acc'(p);
    endfunction

    // kernel [1 0 1; 0 2 0; -1 0 -1], side columns and top row masked at the edge
    function automatic t_acc tap_sum(input t_pix tl, input t_pix bl, input t_pix mc,
                                     input t_pix tr, input t_pix br,
                                     input logic l_ok, input logic r_ok,
                                     input logic top_ok);
        t_acc s;
        s = sx(mc) + sx(mc);
        if (l_ok) begin
            if (top_ok) begin
                s = s + sx(tl);
            end
            s = s - sx(bl);
        end
        if (r_ok) begin
            if (top_ok) begin
                s = s + sx(tr);
            end
            s = s - sx(br);
        end
        return s;
    endfunction

endpackage
`default_nettype wire

// ===== design/conv3x3_zero_padded_stream_top.sv =====
// Top level: 3x3 zero-padded stream convolver with line stores and result queue.
// Each result is written to the four-entry queue when its beat is accepted.
// Throughput: one input beat per cycle while o_in_ready is high; a row-end pixel
// may queue two results; output drains one per cycle while i_out_ready is high.
// Reset: synchronous active low; clears counters, queue and geometry (1024x1024).
// Line stores are not cleared; entries are only read after the frame wrote them.
`timescale 1ns / 1ps
`default_nettype none
module conv3x3_zero_padded_stream_top
    import conv3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,

    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire logic                  i_cmd,
    input  wire t_pix                  i_pixel,

    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_acc                       o_result,
    output t_row                       o_out_row,
    output t_col                       o_out_col,
    output logic                       o_frame_end,
    output logic                       o_last
);

    // geometry and frame position
    t_width r_width,  n_width;
    t_row   r_height, n_height;
    t_row   r_in_row, n_in_row;
    t_col   r_in_col, n_in_col;
    t_col   r_drain,  n_drain;

    // window columns 1 and 2 (index 0 top, 1 middle, 2 bottom)
    t_pix   r_win1 [3];
    t_pix   r_win2 [3];

    // line stores with registered reads and write-through forwarding
    t_pix   r_mem_up [MAX_WIDTH];
    t_pix   r_mem_lo [MAX_WIDTH];
    t_pix   r_rd_a, r_rd_b, r_rd_l;
    t_pix   r_fwd_up, r_fwd_lo;
    logic   r_fwd_a, r_fwd_b, r_fwd_l;
    t_col   rd_addr_a, rd_addr_b, rd_addr_l;
    t_pix   up_a, up_b, lo;

    // result queue
    t_res   r_q [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count, n_count;

    logic   cfg_wr, cfg_restart, acc_in, pop;
    logic   full, is_px, is_dr, row_end, drain_end, n_full;
    logic   row_ok, top_ok, j_ge1, j_ge2, h_ge2;
    t_width wv;
    t_acc   res1, res2, dsum;
    t_res   e0, e1;
    logic [1:0] push_n;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_count <= QCNT_W'(QDEPTH - 2));
    assign cfg_wr      = i_cfg_valid & o_cfg_ready;
    assign acc_in      = i_in_valid & o_in_ready;
    assign o_out_valid = (r_count != '0);
    assign pop         = o_out_valid & i_out_ready;

    assign up_a = r_fwd_a ? r_fwd_up : r_rd_a;
    assign up_b = r_fwd_b ? r_fwd_up : r_rd_b;
    assign lo   = r_fwd_l ? r_fwd_lo : r_rd_l;

    assign full      = (r_in_row >= r_height);
    assign is_px     = acc_in & (i_cmd == CMD_PIXEL) & ~full;
    assign is_dr     = acc_in & (i_cmd == CMD_DRAIN) & full;
    assign row_end   = ((WIDTH_W'(r_in_col) + WIDTH_W'(1)) >= r_width);
    assign drain_end = ((WIDTH_W'(r_drain) + WIDTH_W'(1)) >= r_width);
    assign row_ok    = (r_in_row != '0);
    assign top_ok    = (r_in_row >= ROW_W'(2));
    assign j_ge1     = (r_in_col != '0);
    assign j_ge2     = (r_in_col >= COL_W'(2));
    assign h_ge2     = (r_height >= ROW_W'(2));

    // taps after the window shift: new col0 = r_win1, col1 = r_win2, col2 = fresh
    assign res1 = tap_sum(r_win1[0], r_win1[2], r_win2[1], up_a, i_pixel,
                          j_ge2, 1'b1, top_ok);
    assign res2 = tap_sum(r_win2[0], r_win2[2], lo, '0, '0, j_ge1, 1'b0, top_ok);

    always_comb begin
        dsum = sx(lo) + sx(lo);
        if (h_ge2) begin
            if (r_drain != '0) begin
                dsum = dsum + sx(up_b);
            end
            if (!drain_end) begin
                dsum = dsum + sx(up_a);
            end
        end
    end

    // frame position and geometry
    always_comb begin
        n_width     = r_width;
        n_height    = r_height;
        n_in_row    = r_in_row;
        n_in_col    = r_in_col;
        n_drain     = r_drain;
        cfg_restart = 1'b0;
        wv          = i_cfg_data[WIDTH_W-1:0];
        if (cfg_wr) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    cfg_restart = 1'b1;
                    if (wv == '0) begin
                        n_width = WIDTH_W'(1);
                    end else if (wv > WIDTH_W'(MAX_WIDTH)) begin
                        n_width = WIDTH_W'(MAX_WIDTH);
                    end else begin
                        n_width = wv;
                    end
                end
                REG_FRAME_HEIGHT: begin
                    cfg_restart = 1'b1;
                    if (i_cfg_data[ROW_W-1:0] == '0) begin
                        n_height = ROW_W'(1);
                    end else begin
                        n_height = i_cfg_data[ROW_W-1:0];
                    end
                end
                default: begin
                    cfg_restart = 1'b0;
                end
            endcase
        end
        if (cfg_restart) begin
            n_in_row = '0;
            n_in_col = '0;
            n_drain  = '0;
        end else if (is_px) begin
            if (row_end) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = r_in_col + COL_W'(1);
            end
        end else if (is_dr) begin
            if (drain_end) begin
                n_in_row = '0;
                n_in_col = '0;
                n_drain  = '0;
            end else begin
                n_drain = r_drain + COL_W'(1);
            end
        end
    end

    // read addresses follow the next position so data is ready for the next beat
    assign n_full    = (n_in_row >= r_height);
    assign rd_addr_a = n_full ? (n_drain + COL_W'(1)) : n_in_col;
    assign rd_addr_b = n_drain - COL_W'(1);
    assign rd_addr_l = n_full ? n_drain : n_in_col;

    always_ff @(posedge i_clk) begin
        if (is_px) begin
            r_mem_up[r_in_col] <= lo;
            r_mem_lo[r_in_col] <= i_pixel;
        end
        r_rd_a <= r_mem_up[rd_addr_a];
        r_rd_b <= r_mem_up[rd_addr_b];
        r_rd_l <= r_mem_lo[rd_addr_l];
    end

    always_ff @(posedge i_clk) begin
        r_fwd_up <= lo;
        r_fwd_lo <= i_pixel;
        if (!i_rst_n) begin
            r_fwd_a <= 1'b0;
            r_fwd_b <= 1'b0;
            r_fwd_l <= 1'b0;
        end else begin
            r_fwd_a <= is_px & (rd_addr_a == r_in_col);
            r_fwd_b <= is_px & (rd_addr_b == r_in_col);
            r_fwd_l <= is_px & (rd_addr_l == r_in_col);
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_px) begin
            r_win1[0] <= r_win2[0];
            r_win1[1] <= r_win2[1];
            r_win1[2] <= r_win2[2];
            r_win2[0] <= up_a;
            r_win2[1] <= lo;
            r_win2[2] <= i_pixel;
        end
    end

    // results caused by this beat, in order
    always_comb begin
        push_n = 2'd0;
        e0     = '0;
        e1     = '0;
        if (is_px && row_ok) begin
            if (j_ge1) begin
                e0 = '{result: res1, row: r_in_row - ROW_W'(1),
                       col: r_in_col - COL_W'(1), frame_end: 1'b0, last: ~row_end};
                e1 = '{result: res2, row: r_in_row - ROW_W'(1),
                       col: r_in_col, frame_end: 1'b0, last: 1'b1};
                push_n = row_end ? 2'd2 : 2'd1;
            end else if (row_end) begin
                e0 = '{result: res2, row: r_in_row - ROW_W'(1),
                       col: r_in_col, frame_end: 1'b0, last: 1'b1};
                push_n = 2'd1;
            end
        end else if (is_dr) begin
            e0 = '{result: dsum, row: r_height - ROW_W'(1),
                   col: r_drain, frame_end: drain_end, last: 1'b1};
            push_n = 2'd1;
        end
    end

    assign n_count = r_count + QCNT_W'(push_n) - QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        if (push_n != 2'd0) begin
            r_q[r_wr] <= e0;
        end
        if (push_n == 2'd2) begin
            r_q[r_wr + QPTR_W'(1)] <= e1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_W'(RESET_WIDTH);
            r_height <= ROW_W'(RESET_HEIGHT);
            r_in_row <= '0;
            r_in_col <= '0;
            r_drain  <= '0;
            r_wr     <= '0;
            r_rd     <= '0;
            r_count  <= '0;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_in_row <= n_in_row;
            r_in_col <= n_in_col;
            r_drain  <= n_drain;
            r_wr     <= r_wr + QPTR_W'(push_n);
            r_rd     <= r_rd + QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

    assign o_result    = r_q[r_rd].result;
    assign o_out_row   = r_q[r_rd].row;
    assign o_out_col   = r_q[r_rd].col;
    assign o_frame_end = r_q[r_rd].frame_end;
    assign o_last      = r_q[r_rd].last;

endmodule
`default_nettype wire

// ===== design/conv3_checker.sv =====
// Checker: port-level properties of the stream convolver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module conv3_checker
    import conv3_pkg::*;
(
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_ready,
    input wire t_acc                  o_result,
    input wire t_row                  o_out_row,
    input wire t_col                  o_out_col,
    input wire logic                  o_frame_end,
    input wire logic                  o_last
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    a_frame_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_last)
        else $error("frame end on a beat that is not last");

    a_pair_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |=> o_out_valid)
        else $error("second result of a row end missing");

    a_pair_next_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_last |=>
            (o_out_row == $past(o_out_row)) &&
            (o_out_col == COL_W'($past(o_out_col) + COL_W'(1))))
        else $error("row end pair not on adjacent columns");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_result) && $stable(o_out_col))
        else $error("output beat changed while stalled");

endmodule

bind conv3x3_zero_padded_stream_top conv3_checker u_conv3_checker (.*);
`default_nettype wire

// ===== tb/conv3_sum_checker.sv =====
// Checker for the 3x3 stream convolver: predicts kernel sums and compares result beats.
`timescale 1ns / 1ps
module conv3_sum_checker
    import conv3_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    input  wire logic                  i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_ready,
    input  wire logic                  i_cmd,
    input  t_pix                       i_pixel,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_ready,
    input  t_acc                       i_result,
    input  t_row                       i_out_row,
    input  t_col                       i_out_col,
    input  wire logic                  i_frame_end,
    input  wire logic                  i_last,
    output int                         o_mismatches,
    output int                         o_outstanding,
    output int                         o_compared
);

    t_pix   upper_line [MAX_WIDTH];
    t_pix   lower_line [MAX_WIDTH];
    t_pix   win [3][3];
    int     row_in;
    int     col_in;
    int     drain_at;
    t_width width_reg;
    t_row   height_reg;
    t_res   owed_sums [$];
    int     mismatches;
    int     compared;

    initial begin
        foreach (upper_line[k]) begin
            upper_line[k] = '0;
            lower_line[k] = '0;
        end
    end

    function automatic int live_width();
        if (width_reg == 0) begin
            return 1;
        end
        if (width_reg > MAX_WIDTH) begin
            return MAX_WIDTH;
        end
        return int'(width_reg);
    endfunction

    function automatic int live_height();
        return (height_reg == 0) ? 1 : int'(height_reg);
    endfunction

    function automatic void rewind_frame();
        foreach (win[r, c]) begin
            win[r][c] = '0;
        end
        row_in   = 0;
        col_in   = 0;
        drain_at = 0;
    endfunction

    // negative column index: neighbor lies outside the frame
    function automatic int kernel_sum(int lc, int cc, int rc, bit top_ok);
        int s;
        s = 2 * int'(win[1][cc]);
        if (lc >= 0) begin
            if (top_ok) begin
                s += int'(win[0][lc]);
            end
            s -= int'(win[2][lc]);
        end
        if (rc >= 0) begin
            if (top_ok) begin
                s += int'(win[0][rc]);
            end
            s -= int'(win[2][rc]);
        end
        return s;
    endfunction

    function automatic void owe(int s, int row, int col, bit fe, bit lst);
        t_res r;
        r.result    = t_acc'(s);
        r.row       = t_row'(row);
        r.col       = t_col'(col);
        r.frame_end = fe;
        r.last      = lst;
        owed_sums.push_back(r);
    endfunction

    function automatic void take_pixel(t_pix px);
        int w;
        int h;
        int i;
        int j;
        bit top_ok;
        bit row_end;
        w = live_width();
        h = live_height();
        i = row_in;
        j = col_in;
        if (i >= h || j >= w) begin
            return;
        end
        for (int r = 0; r < 3; r++) begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2]     = upper_line[j];
        win[1][2]     = lower_line[j];
        win[2][2]     = px;
        upper_line[j] = lower_line[j];
        lower_line[j] = px;
        if (i >= 1) begin
            top_ok  = (i >= 2);
            row_end = (j + 1 >= w);
            if (j >= 1) begin
                owe(kernel_sum(j >= 2 ? 0 : -1, 1, 2, top_ok), i - 1, j - 1, 1'b0, !row_end);
            end
            if (row_end) begin
                owe(kernel_sum(j >= 1 ? 1 : -1, 2, -1, top_ok), i - 1, j, 1'b0, 1'b1);
            end
        end
        col_in = j + 1;
        if (col_in >= w) begin
            col_in = 0;
            row_in = i + 1;
        end
    endfunction

    function automatic void take_drain();
        int w;
        int h;
        int c;
        int s;
        bit fe;
        w = live_width();
        h = live_height();
        c = drain_at;
        if (row_in < h || c >= w) begin
            return;
        end
        s = 2 * int'(lower_line[c]);
        if (h >= 2) begin
            if (c >= 1) begin
                s += int'(upper_line[c - 1]);
            end
            if (c + 1 < w) begin
                s += int'(upper_line[c + 1]);
            end
        end
        fe = (c + 1 >= w);
        owe(s, h - 1, c, fe, 1'b1);
        drain_at = c + 1;
        if (fe) begin
            rewind_frame();
        end
    endfunction

    function automatic void take_config(logic [CFG_IDX_W-1:0] idx,
                                        logic [CFG_DATA_W-1:0] data);
        if (idx == REG_FRAME_WIDTH) begin
            width_reg = t_width'(data);
            rewind_frame();
        end else if (idx == REG_FRAME_HEIGHT) begin
            height_reg = t_row'(data);
            rewind_frame();
        end
    endfunction

    function automatic void check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            width_reg  = t_width'(RESET_WIDTH);
            height_reg = t_row'(RESET_HEIGHT);
            rewind_frame();
            owed_sums.delete();
            mismatches = 0;
            compared   = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (owed_sums.size() == 0) begin
                    $display("%0t: result beat with none expected: actual %0d row %0d col %0d",
                             $time, i_result, i_out_row, i_out_col);
                    mismatches++;
                end else begin
                    want = owed_sums.pop_front();
                    compared++;
                    check_field("result", want.result, i_result);
                    check_field("out_row", want.row, i_out_row);
                    check_field("out_col", want.col, i_out_col);
                    check_field("frame_end", want.frame_end, i_frame_end);
                    check_field("last", want.last, i_last);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                take_config(i_cfg_index, i_cfg_data);
            end
            if (i_in_valid && i_in_ready) begin
                if (i_cmd == CMD_DRAIN) begin
                    take_drain();
                end else begin
                    take_pixel(i_pixel);
                end
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= owed_sums.size();
        o_compared    <= compared;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top: drives frames, drain ticks and geometry writes into the 3x3 convolver.
`timescale 1ns / 1ps
module tb_top;
    import conv3_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam int ITEM_BEATS    = 1800;
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    logic                  i_cmd       = CMD_PIXEL;
    t_pix                  i_pixel     = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_acc                  o_result;
    t_row                  o_out_row;
    t_col                  o_out_col;
    logic                  o_frame_end;
    logic                  o_last;

    int mismatches;
    int outstanding;
    int compared;

    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;
    int live_w;
    int live_h;
    int useful;
    int frames;

    conv3x3_zero_padded_stream_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_pixel     (i_pixel),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (o_result),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_frame_end (o_frame_end),
        .o_last      (o_last)
    );

    conv3_sum_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_pixel       (i_pixel),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_result      (o_result),
        .i_out_row     (o_out_row),
        .i_out_col     (o_out_col),
        .i_frame_end   (o_frame_end),
        .i_last        (o_last),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #25_000_000;
        $display("tb_top failed");
        $finish;
    end

    // result side: random stall bursts
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 18) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic t_pix pick_pixel();
        case ($urandom_range(0, 11))
            0:       return t_pix'(16'h8000);
            1:       return t_pix'(16'h7FFF);
            2:       return '0;
            3:       return '1;
            default: return t_pix'($urandom);
        endcase
    endfunction

    task automatic send_beat(logic cmd, t_pix px);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_pixel    <= px;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    // wait until every predicted result has left, then let the design settle
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_geometry(t_width w_reg, t_row h_reg);
        settle();
        write_reg(REG_FRAME_WIDTH, w_reg);
        write_reg(REG_FRAME_HEIGHT, h_reg);
        i_cfg_valid <= 1'b0;
        live_w = (w_reg == 0) ? 1 : (w_reg > MAX_WIDTH) ? MAX_WIDTH : int'(w_reg);
        live_h = (h_reg == 0) ? 1 : int'(h_reg);
    endtask

    // cut below the frame size leaves the frame unfinished
    task automatic stream_frame(bit noisy, int cut);
        for (int k = 0; k < cut; k++) begin
            if (noisy && $urandom_range(0, 19) == 0) begin
                send_beat(CMD_DRAIN, pick_pixel());
            end
            send_beat(CMD_PIXEL, pick_pixel());
            useful++;
        end
        if (cut < live_w * live_h) begin
            return;
        end
        if (noisy && $urandom_range(0, 3) == 0) begin
            send_beat(CMD_PIXEL, pick_pixel());
        end
        for (int c = 0; c < live_w; c++) begin
            send_beat(CMD_DRAIN, pick_pixel());
            useful++;
        end
        frames++;
    endtask

    initial begin
        int     cut;
        bit     whole;
        bit     calm;
        t_width w_reg;
        t_row   h_reg;

        whole = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // 3x2 frame: pixel extremes, stray drain before, stray pixel after
        set_geometry(11'd3, 16'd2);
        send_beat(CMD_DRAIN, '0);
        send_beat(CMD_PIXEL, t_pix'(16'h7FFF));
        send_beat(CMD_PIXEL, t_pix'(16'h8000));
        send_beat(CMD_PIXEL, '0);
        send_beat(CMD_PIXEL, '1);
        send_beat(CMD_PIXEL, t_pix'(16'h0001));
        send_beat(CMD_PIXEL, t_pix'(16'h8000));
        send_beat(CMD_PIXEL, t_pix'(16'h1234));
        repeat (3) send_beat(CMD_DRAIN, t_pix'(16'h7FFF));
        useful += 9;
        frames++;

        // zero width and height act as one
        set_geometry(11'd0, 16'd0);
        send_beat(CMD_PIXEL, t_pix'(16'h8000));
        send_beat(CMD_DRAIN, '0);
        useful += 2;
        frames++;

        // single column; writes to unused indexes mid-frame leave it running
        set_geometry(11'd1, 16'd3);
        send_beat(CMD_PIXEL, t_pix'(16'h8000));
        settle();
        write_reg(REG_SPARE_2, 16'hFFFF);
        write_reg(REG_SPARE_3, 16'hFFFF);
        i_cfg_valid <= 1'b0;
        send_beat(CMD_PIXEL, t_pix'(16'h7FFF));
        send_beat(CMD_PIXEL, '1);
        send_beat(CMD_DRAIN, '0);
        useful += 4;
        frames++;

        // tallest frame, abandoned early
        set_geometry(11'd3, 16'hFFFF);
        repeat (8) send_beat(CMD_PIXEL, pick_pixel());
        useful += 8;

        // width beyond the line store acts as full width: the row wraps at the
        // line store size and the next row starts producing results
        set_geometry(11'h7FF, 16'd2);
        stream_frame(1'b0, live_w + 2);

        while (useful < ITEM_BEATS) begin
            calm     = useful > ITEM_BEATS * 4 / 5;
            idle_on  = !calm && $urandom_range(0, 3) != 0;
            stall_on = !calm && $urandom_range(0, 3) != 0;
            if (!whole || $urandom_range(0, 2) != 0) begin
                if ($urandom_range(0, 19) == 0) begin
                    w_reg = '0;
                end else if ($urandom_range(0, 9) == 0) begin
                    w_reg = t_width'($urandom_range(13, 48));
                end else begin
                    w_reg = t_width'($urandom_range(1, 12));
                end
                if ($urandom_range(0, 19) == 0) begin
                    h_reg = '0;
                end else if ($urandom_range(0, 7) == 0) begin
                    h_reg = t_row'($urandom_range(9, 24));
                end else begin
                    h_reg = t_row'($urandom_range(1, 8));
                end
                set_geometry(w_reg, h_reg);
            end
            cut   = live_w * live_h;
            whole = 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) begin
                cut   = $urandom_range(0, cut - 1);
                whole = 1'b0;
            end
            // keep the last frame from running far past the beat budget
            if (cut > ITEM_BEATS - useful + 60) begin
                cut   = ITEM_BEATS - useful;
                whole = 1'b0;
            end
            stream_frame($urandom_range(0, 1), cut);
        end

        idle_on  = 1'b0;
        stall_on = 1'b0;
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
        repeat (20) @(posedge i_clk);

        $display("Streamed %0d complete frames in %0d pixel and drain beats",
                 frames, useful);
        $display("Compared %0d convolution results against predicted sums", compared);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
